[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the job table controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define JT_ASSERT(lbl, clk_, rst_, prop, msg) \
  lbl: assert property (@(posedge clk_) disable iff (rst_) (prop)) else $error(msg);
// expr must never be true out of reset
`define JT_ASSERT_NEVER(lbl, clk_, rst_, expr, msg) \
  lbl: assert property (@(posedge clk_) disable iff (rst_) !(expr)) else $error(msg);
`else
`define JT_ASSERT(lbl, clk_, rst_, prop, msg)
`define JT_ASSERT_NEVER(lbl, clk_, rst_, expr, msg)
`endif
`endif

[sv/jtid_pkg.sv]
// ----------------------------------------------------------------------------
// jtid_pkg
// Types, codes and sizes for the job table with job id allocation.
// ----------------------------------------------------------------------------
`default_nettype none

package jtid_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int PID_BITS    = 22;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  // stored job ids grow past the slot count after delete/add pairs; keep full width
  localparam int JOB_BITS    = 32;

  // operation kinds
  localparam logic [2:0] KIND_ADD      = 3'd0;
  localparam logic [2:0] KIND_DEL      = 3'd1;
  localparam logic [2:0] KIND_FIND_PID = 3'd2;
  localparam logic [2:0] KIND_FIND_JOB = 3'd3;
  localparam logic [2:0] KIND_FG       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BAD_ID   = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] RUN_FG = 2'd1;

  typedef struct packed {
    logic [2:0]          kind;
    logic [PID_BITS-1:0] process_id;
    logic [7:0]          job_id;
    logic [1:0]          new_state;
    logic                write_state;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PID_BITS-1:0] found_process_id;
    logic [4:0]          found_job_id;
    logic [1:0]          found_state;
    logic [3:0]          found_slot;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic apply;
    logic sweep;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic del_done;
    logic sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/jtid_dp.sv]
// ----------------------------------------------------------------------------
// jtid_dp
// Datapath: entry table, item register, slot match and pick, next job id,
// max sweep after delete, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jtid_dp import jtid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsp_t     rsp
);

  req_t                item;
  logic [PID_BITS-1:0] ent_pid   [TABLE_SLOTS];
  logic [JOB_BITS-1:0] ent_job   [TABLE_SLOTS];
  logic [1:0]          ent_state [TABLE_SLOTS];
  logic [JOB_BITS-1:0] next_job;
  logic                hit;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   sweep_cnt;
  logic [JOB_BITS-1:0] job_max;

  logic [TABLE_SLOTS-1:0] match;
  logic                   pick_hit;
  logic [SLOT_W-1:0]      pick_slot;
  logic [PID_BITS-1:0]    sel_pid;
  logic [JOB_BITS-1:0]    sel_job;
  logic [1:0]             sel_state;
  logic [1:0]             res_status;
  rsp_t                   res;
  logic [JOB_BITS-1:0]    next_inc;
  logic [JOB_BITS-1:0]    next_after_add;
  logic [JOB_BITS-1:0]    sweep_job;
  logic [JOB_BITS-1:0]    sweep_max;

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
  end

  // per-slot match for the current kind
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      case (item.kind)
        KIND_ADD:                match[i] = (ent_pid[i] == '0);
        KIND_DEL, KIND_FIND_PID: match[i] = (ent_pid[i] == item.process_id);
        KIND_FIND_JOB:           match[i] = (ent_job[i] == JOB_BITS'(item.job_id));
        KIND_FG:                 match[i] = (ent_state[i] == RUN_FG);
        default:                 match[i] = 1'b0;
      endcase
    end
  end

  // lowest matching slot wins
  always_comb begin
    pick_hit  = |match;
    pick_slot = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        pick_slot = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit  <= pick_hit;
      slot <= pick_slot;
    end
  end

  assign sel_pid   = ent_pid[slot];
  assign sel_job   = ent_job[slot];
  assign sel_state = ent_state[slot];

  assign next_inc       = next_job + JOB_BITS'(1);
  assign next_after_add = (next_inc > JOB_BITS'(TABLE_SLOTS)) ? JOB_BITS'(1) : next_inc;

  always_comb begin
    case (item.kind)
      KIND_ADD: begin
        if (item.process_id == '0) begin
          res_status = ST_BAD_ID;
        end else if (!hit) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_DONE;
        end
      end
      KIND_DEL, KIND_FIND_PID: begin
        if (item.process_id == '0) begin
          res_status = ST_BAD_ID;
        end else if (!hit) begin
          res_status = ST_NO_MATCH;
        end else begin
          res_status = ST_DONE;
        end
      end
      KIND_FIND_JOB: begin
        if (item.job_id == '0) begin
          res_status = ST_BAD_ID;
        end else if (!hit) begin
          res_status = ST_NO_MATCH;
        end else begin
          res_status = ST_DONE;
        end
      end
      KIND_FG: begin
        res_status = hit ? ST_DONE : ST_NO_MATCH;
      end
      default: begin
        res_status = ST_NO_MATCH;
      end
    endcase
  end

  // result fields show the entry after the op; delete reports the old ids
  always_comb begin
    res = '0;
    res.status = res_status;
    if (res_status == ST_DONE) begin
      res.found_process_id = sel_pid;
      res.found_job_id     = sel_job[4:0];
      res.found_state      = sel_state;
      res.found_slot       = 4'(slot);
      case (item.kind)
        KIND_ADD: begin
          res.found_process_id = item.process_id;
          res.found_job_id     = next_job[4:0];
          res.found_state      = item.new_state;
        end
        KIND_DEL: begin
          res.found_state = 2'd0;
        end
        KIND_FIND_PID, KIND_FIND_JOB: begin
          if (item.write_state) begin
            res.found_state = item.new_state;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sweep_job = ent_job[sweep_cnt];
  assign sweep_max = (sweep_job > job_max) ? sweep_job : job_max;

  // table and next job id
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        ent_pid[i]   <= '0;
        ent_job[i]   <= '0;
        ent_state[i] <= '0;
      end
      next_job <= JOB_BITS'(1);
    end else if (cmd.apply && res_status == ST_DONE) begin
      case (item.kind)
        KIND_ADD: begin
          ent_pid[slot]   <= item.process_id;
          ent_job[slot]   <= next_job;
          ent_state[slot] <= item.new_state;
          next_job        <= next_after_add;
        end
        KIND_DEL: begin
          ent_pid[slot]   <= '0;
          ent_job[slot]   <= '0;
          ent_state[slot] <= '0;
        end
        KIND_FIND_PID, KIND_FIND_JOB: begin
          if (item.write_state) begin
            ent_state[slot] <= item.new_state;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.sweep && stat.sweep_last) begin
      next_job <= sweep_max + JOB_BITS'(1);
    end
  end

  // max sweep over stored job ids, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.apply) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      job_max <= '0;
    end else if (cmd.sweep) begin
      job_max <= sweep_max;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.apply) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp <= res;
    end
  end

  assign stat.out_free   = !rsp_valid || rsp_ready;
  assign stat.del_done   = (item.kind == KIND_DEL) && (res_status == ST_DONE);
  assign stat.sweep_last = (sweep_cnt == SLOT_W'(TABLE_SLOTS - 1));

endmodule

`default_nettype wire

[sv/jtid_ctrl.sv]
// ----------------------------------------------------------------------------
// jtid_ctrl
// Controller: sequences load, lookup, apply and the post-delete max sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jtid_ctrl import jtid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;
  localparam logic [1:0] S_SWEEP  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        // hold until the result register can take the item
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = stat.del_done ? S_SWEEP : S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `JT_ASSERT_NEVER(a_apply_full, clk, rst, cmd.apply && !stat.out_free, "apply with result held")
  `JT_ASSERT(a_load_lookup, clk, rst, cmd.load |=> cmd.lookup, "lookup did not follow load")
  `JT_ASSERT(a_sweep_end, clk, rst, cmd.sweep && stat.sweep_last |=> req_ready, "sweep did not end")

endmodule

`default_nettype wire

[sv/job_table_with_id_allocation_top.sv]
// Sequence: an item is accepted in idle, looked up in the next cycle and its result is
//   registered in apply, which waits until the result register is free.
// Items: a new item is accepted only in idle, once the last one is applied; a successful
//   delete also waits for the max sweep over stored job ids, one slot per cycle.
// Reset (rst, synchronous): all slots free, job ids and states zero, next job id 1.
// ----------------------------------------------------------------------------
// job_table_with_id_allocation_top
// Table of process entries with job id allocation: add, delete, find by
// process id or job id with optional restate, and foreground query.
// ----------------------------------------------------------------------------
`default_nettype none

module job_table_with_id_allocation_top import jtid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: idle -> lookup -> apply, then a sweep after a delete that
  // hit, to recompute the next job id as the largest stored id plus one.
  jtid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: entries in flops, parallel slot compare with lowest-slot pick,
  // and a result register that frees the input side while an item waits.
  jtid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[tb/tb_job_table_with_id_allocation_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_job_table_with_id_allocation_top
// Self-checking bench for the job table: a shadow copy of the slot table
// predicts every reply, and each reply is checked in order, field by field.
// A short directed run of edge cases leads into random command streams,
// played with and without idle gaps on the command and reply sides.
// ----------------------------------------------------------------------------

module tb_job_table_with_id_allocation_top;
  import jtid_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [PID_BITS-1:0] PID_MAX = '1;
  localparam int RANDOM_ITEMS = 500;
  localparam int STALL_LIMIT  = 5000;

  // Shadow job table: predicts each reply and checks the DUT against it.
  class job_table_tracker;
    logic [PID_BITS-1:0] slot_pid [TABLE_SLOTS];
    int unsigned         slot_job [TABLE_SLOTS];
    logic [1:0]          slot_run [TABLE_SLOTS];
    int unsigned         next_job;
    rsp_t                pending_results [$];
    int                  errors;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_pid[i] = '0;
        slot_job[i] = 0;
        slot_run[i] = '0;
      end
      next_job = 1;
      errors   = 0;
    endfunction

    function int first_slot_with_pid(logic [PID_BITS-1:0] pid);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_pid[i] == pid) return i;
      end
      return -1;
    endfunction

    function rsp_t slot_reply(int s);
      rsp_t r;
      r.status           = ST_DONE;
      r.found_process_id = slot_pid[s];
      r.found_job_id     = 5'(slot_job[s]);
      r.found_state      = slot_run[s];
      r.found_slot       = 4'(s);
      return r;
    endfunction

    // Apply one accepted command to the shadow table and queue its reply.
    function void note_request(req_t r);
      rsp_t        e;
      int          s;
      int unsigned top;
      e = '0;
      s = -1;
      case (r.kind)
        KIND_ADD: begin
          if (r.process_id == '0) begin
            e.status = ST_BAD_ID;
          end else begin
            s = first_slot_with_pid('0);
            if (s < 0) begin
              e.status = ST_FULL;
            end else begin
              slot_pid[s] = r.process_id;
              slot_run[s] = r.new_state;
              slot_job[s] = next_job;
              next_job++;
              if (next_job > TABLE_SLOTS) next_job = 1;
              e = slot_reply(s);
            end
          end
        end
        KIND_DEL: begin
          if (r.process_id == '0) begin
            e.status = ST_BAD_ID;
          end else begin
            s = first_slot_with_pid(r.process_id);
            if (s < 0) begin
              e.status = ST_NO_MATCH;
            end else begin
              e = slot_reply(s);
              e.found_state = '0;
              slot_pid[s] = '0;
              slot_job[s] = 0;
              slot_run[s] = '0;
              top = 0;
              for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_job[i] > top) top = slot_job[i];
              end
              next_job = top + 1;
            end
          end
        end
        KIND_FIND_PID, KIND_FIND_JOB: begin
          if (r.kind == KIND_FIND_PID) begin
            if (r.process_id == '0) e.status = ST_BAD_ID;
            else s = first_slot_with_pid(r.process_id);
          end else begin
            if (r.job_id == '0) begin
              e.status = ST_BAD_ID;
            end else begin
              for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (s < 0 && slot_job[i] == r.job_id) s = i;
              end
            end
          end
          if (e.status == ST_DONE) begin
            if (s < 0) begin
              e.status = ST_NO_MATCH;
            end else begin
              if (r.write_state) slot_run[s] = r.new_state;
              e = slot_reply(s);
            end
          end
        end
        KIND_FG: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (s < 0 && slot_run[i] == RUN_FG) s = i;
          end
          if (s < 0) e.status = ST_NO_MATCH;
          else e = slot_reply(s);
        end
        default: e.status = ST_NO_MATCH;
      endcase
      pending_results.push_back(e);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted reply with the oldest prediction.
    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status",           want.status,           got.status);
      check_field("found_process_id", want.found_process_id, got.found_process_id);
      check_field("found_job_id",     want.found_job_id,     got.found_job_id);
      check_field("found_state",      want.found_state,      got.found_state);
      check_field("found_slot",       want.found_slot,       got.found_slot);
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  job_table_tracker jobs = new();

  job_table_with_id_allocation_top uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  // Reply side: stall at random and check every accepted reply.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) jobs.check_response(rsp);
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: abort when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_job_table_with_id_allocation_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [PID_BITS-1:0] pid,
                                    logic [7:0] jid, logic [1:0] run, logic wr);
    req_t r;
    r.kind        = kind;
    r.process_id  = pid;
    r.job_id      = jid;
    r.new_state   = run;
    r.write_state = wr;
    return r;
  endfunction

  // Draw mostly from a small pool so duplicates and re-adds are common.
  function automatic logic [PID_BITS-1:0] pool_pid();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return PID_BITS'($urandom_range(1, 40));
    if (pick < 90) return PID_BITS'($urandom);
    return PID_MAX - PID_BITS'($urandom_range(0, 15));
  endfunction

  // Prefer a process id that currently sits in the table.
  function automatic logic [PID_BITS-1:0] live_pid();
    int s;
    s = $urandom_range(0, TABLE_SLOTS - 1);
    if (jobs.slot_pid[s] != '0 && $urandom_range(0, 99) < 80) return jobs.slot_pid[s];
    return pool_pid();
  endfunction

  function automatic req_t random_item();
    req_t r;
    int   pick;
    r = make_req(KIND_ADD, pool_pid(), 8'($urandom_range(1, 17)),
                 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.kind = KIND_ADD;
    end else if (pick < 50) begin
      r.kind       = KIND_DEL;
      r.process_id = live_pid();
    end else if (pick < 68) begin
      r.kind       = KIND_FIND_PID;
      r.process_id = live_pid();
    end else if (pick < 83) begin
      r.kind = KIND_FIND_JOB;
      if ($urandom_range(0, 9) == 0) r.job_id = 8'($urandom_range(0, 255));
    end else if (pick < 93) begin
      r.kind = KIND_FG;
    end else begin
      // noise: any kind, including the unused ones, with bad or stray ids
      r.kind       = 3'($urandom_range(0, KIND_UNUSED_HI));
      r.process_id = $urandom_range(0, 1) ? '0 : PID_BITS'($urandom);
      r.job_id     = 8'($urandom);
    end
    return r;
  endfunction

  // Offer one item, idling first at random; return once it is accepted.
  task automatic send_item(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    jobs.note_request(r);
  endtask

  // Hold off the sender until every predicted reply has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (jobs.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bad ids, misses and unused kinds on an empty table.
    send_item(make_req(KIND_FG,        '0,     8'd0,   2'd0, 1'b0));
    send_item(make_req(KIND_ADD,       '0,     8'd1,   2'd1, 1'b0));
    send_item(make_req(KIND_FIND_JOB,  22'd7,  8'd0,   2'd0, 1'b0));
    send_item(make_req(KIND_FIND_PID,  '0,     8'd1,   2'd0, 1'b1));
    send_item(make_req(KIND_DEL,       '0,     8'd0,   2'd0, 1'b0));
    send_item(make_req(KIND_DEL,       22'd5,  8'd0,   2'd0, 1'b0));
    send_item(make_req(KIND_UNUSED_LO, 22'd5,  8'd1,   2'd1, 1'b1));
    send_item(make_req(KIND_UNUSED_HI, PID_MAX, 8'hFF, 2'd3, 1'b1));

    // Fill every slot (job ids 1..16, next id wraps), then overflow.
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      send_item(make_req(KIND_ADD, (i == 0) ? PID_MAX : PID_BITS'(100 + i), 8'd0,
                         2'(i % 4), 1'b0));
    end
    send_item(make_req(KIND_ADD, 22'd999, 8'd0, 2'd2, 1'b0));

    // Restate slot 0 to foreground, then free slot 1 so the next id becomes 17.
    send_item(make_req(KIND_FIND_PID, PID_MAX,  8'd0,   RUN_FG, 1'b1));
    send_item(make_req(KIND_DEL,      22'd101,  8'd0,   2'd0,   1'b0));
    send_item(make_req(KIND_ADD,      22'd500,  8'd0,   2'd3,   1'b0));
    send_item(make_req(KIND_FIND_JOB, '0,       8'd17,  2'd2,   1'b0));
    send_item(make_req(KIND_FIND_JOB, '0,       8'd255, 2'd0,   1'b0));
    send_item(make_req(KIND_FG,       '0,       8'd0,   2'd0,   1'b0));
    drain();

    // Random: four idling patterns, draining fully between them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_item(random_item());
      drain();
    end

    // Let any late extra reply show up before judging.
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (jobs.pending_results.size() != 0) begin
      $display("%0t: replies missing: expected %0d more, actual 0", $time,
               jobs.pending_results.size());
      jobs.errors++;
    end
    if (jobs.errors == 0) begin
      $display("tb_job_table_with_id_allocation_top OK");
    end else begin
      $display("tb_job_table_with_id_allocation_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/jtid_pkg.sv
sv/jtid_dp.sv
sv/jtid_ctrl.sv
sv/job_table_with_id_allocation_top.sv
tb/tb_job_table_with_id_allocation_top.sv
